// ===== sv/sdrd_pkg.sv =====
`default_nettype none
package sdrd_pkg;

    localparam int BLOCK_BYTES = 512;
    localparam int STEP_W      = 10;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 24;

    localparam logic [7:0] CMD_READ_SINGLE = 8'h40 | 8'd17;
    localparam logic [7:0] FILL_BYTE       = 8'hFF;
    localparam logic [7:0] START_TOKEN     = 8'hFE;

    localparam logic [23:0] OFFSET_RESET      = 24'd775;
    localparam logic [7:0]  RESP_TRIES_RESET  = 8'd8;
    localparam logic [9:0]  TOKEN_TRIES_RESET = 10'h2FF;

    // register indexes on the config port
    localparam logic [CFG_IDX_W-1:0] REG_BLOCK_OFFSET   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_RESPONSE_TRIES = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TOKEN_TRIES    = 2'd2;

    localparam logic [1:0] ERR_NONE     = 2'd0;
    localparam logic [1:0] ERR_RESPONSE = 2'd1;
    localparam logic [1:0] ERR_TIMEOUT  = 2'd2;
    localparam logic [1:0] ERR_TOKEN    = 2'd3;

    localparam logic REQ_START = 1'b0;
    localparam logic REQ_RX    = 1'b1;

    typedef struct packed {
        logic        req_type;
        logic [23:0] block_number;
        logic [7:0]  rx_byte;
    } sdrd_in_t;

    typedef struct packed {
        logic       tx_valid;
        logic [7:0] tx_byte;
        logic       card_select;
        logic       data_valid;
        logic [7:0] data_byte;
        logic       data_last;
        logic       done_res;
        logic [1:0] error_code;
        logic [7:0] fault_byte;
    } sdrd_out_t;

endpackage
`default_nettype wire

// ===== sv/sd_spi_block_read_sequencer_core.sv =====
// SD card single-block read sequencer, SPI mode, host side. Each input item is
// either a start request carrying a block number or the byte received during the
// previous SPI exchange; each item yields exactly one result item naming the next
// byte to exchange, an optional payload byte, and at the end a done flag with an
// error code. One item is taken per clock: the next state and the result are
// formed in a single pass and held in one output register, so a new item is
// accepted whenever that register is empty or is being taken in the same cycle.
// Configuration writes (block offset, response and token poll limits) must be
// made while no read is in flight.
`default_nettype none
module sd_spi_block_read_sequencer_core
    import sdrd_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    input  wire logic                  s_valid,
    output      logic                  s_ready,
    input  wire sdrd_in_t              s_item,
    output      logic                  m_valid,
    input  wire logic                  m_ready,
    output      sdrd_out_t             m_item
);

    localparam logic [2:0] PH_IDLE  = 3'd0;
    localparam logic [2:0] PH_CMD   = 3'd1;
    localparam logic [2:0] PH_RESP  = 3'd2;
    localparam logic [2:0] PH_EXTRA = 3'd3;
    localparam logic [2:0] PH_TOKEN = 3'd4;
    localparam logic [2:0] PH_DATA  = 3'd5;
    localparam logic [2:0] PH_TRAIL = 3'd6;

    logic [23:0]       offset_reg;
    logic [7:0]        resp_tries_reg;
    logic [9:0]        token_tries_reg;

    logic [2:0]        phase_reg, phase_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic [22:0]       addr_reg, addr_next;   // byte address bits 31:9
    logic [7:0]        last_resp_reg, last_resp_next;

    logic              m_valid_reg;
    sdrd_out_t         out_reg, out_next;

    logic              accept;
    logic [23:0]       blk_sum;
    logic [STEP_W-1:0] step_inc;
    logic [7:0]        addr_byte;

    assign s_ready = !m_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;
    assign m_valid = m_valid_reg;
    assign m_item  = out_reg;

    assign blk_sum  = s_item.block_number + offset_reg;
    assign step_inc = step_reg + STEP_W'(1);

    always_comb begin
        case (step_reg[2:0])
            3'd1:    addr_byte = addr_reg[22:15];
            3'd2:    addr_byte = addr_reg[14:7];
            3'd3:    addr_byte = {addr_reg[6:0], 1'b0};
            default: addr_byte = 8'h00;
        endcase
    end

    always_comb begin
        phase_next     = phase_reg;
        step_next      = step_reg;
        addr_next      = addr_reg;
        last_resp_next = last_resp_reg;
        out_next       = '0;

        if (s_item.req_type == REQ_START) begin
            addr_next            = blk_sum[22:0];
            last_resp_next       = FILL_BYTE;
            phase_next           = PH_CMD;
            step_next            = STEP_W'(1);
            out_next.tx_valid    = 1'b1;
            out_next.card_select = 1'b1;
            out_next.tx_byte     = CMD_READ_SINGLE;
        end else begin
            case (phase_reg)
                PH_CMD: begin
                    out_next.tx_valid    = 1'b1;
                    out_next.card_select = 1'b1;
                    out_next.tx_byte     = FILL_BYTE;
                    if (step_reg >= STEP_W'(1) && step_reg <= STEP_W'(4)) begin
                        out_next.tx_byte = addr_byte;
                        step_next        = step_inc;
                    end else if (step_reg == STEP_W'(5)) begin
                        step_next = STEP_W'(6);
                    end else begin
                        phase_next = PH_RESP;
                        step_next  = STEP_W'(1);
                    end
                end
                PH_RESP: begin
                    out_next.tx_valid    = 1'b1;
                    out_next.card_select = 1'b1;
                    out_next.tx_byte     = FILL_BYTE;
                    if (s_item.rx_byte != FILL_BYTE ||
                        step_reg >= STEP_W'(resp_tries_reg)) begin
                        last_resp_next = s_item.rx_byte;
                        phase_next     = PH_EXTRA;
                        step_next      = '0;
                    end else begin
                        step_next = step_inc;
                    end
                end
                PH_EXTRA: begin
                    if (last_resp_reg != 8'h00) begin
                        out_next.done_res   = 1'b1;
                        out_next.error_code = ERR_RESPONSE;
                        out_next.fault_byte = last_resp_reg;
                        phase_next          = PH_IDLE;
                        step_next           = '0;
                    end else begin
                        out_next.tx_valid    = 1'b1;
                        out_next.card_select = 1'b1;
                        out_next.tx_byte     = FILL_BYTE;
                        phase_next           = PH_TOKEN;
                        step_next            = STEP_W'(1);
                    end
                end
                PH_TOKEN: begin
                    if (s_item.rx_byte == START_TOKEN) begin
                        out_next.tx_valid    = 1'b1;
                        out_next.card_select = 1'b1;
                        out_next.tx_byte     = FILL_BYTE;
                        phase_next           = PH_DATA;
                        step_next            = '0;
                    end else if (s_item.rx_byte != FILL_BYTE) begin
                        out_next.done_res   = 1'b1;
                        out_next.error_code = ERR_TOKEN;
                        out_next.fault_byte = s_item.rx_byte;
                        phase_next          = PH_IDLE;
                        step_next           = '0;
                    end else if (step_reg >= token_tries_reg) begin
                        out_next.done_res   = 1'b1;
                        out_next.error_code = ERR_TIMEOUT;
                        out_next.fault_byte = s_item.rx_byte;
                        phase_next          = PH_IDLE;
                        step_next           = '0;
                    end else begin
                        out_next.tx_valid    = 1'b1;
                        out_next.card_select = 1'b1;
                        out_next.tx_byte     = FILL_BYTE;
                        step_next            = step_inc;
                    end
                end
                PH_DATA: begin
                    out_next.tx_valid    = 1'b1;
                    out_next.card_select = 1'b1;
                    out_next.tx_byte     = FILL_BYTE;
                    out_next.data_valid  = 1'b1;
                    out_next.data_byte   = s_item.rx_byte;
                    step_next            = step_inc;
                    if (step_inc >= STEP_W'(BLOCK_BYTES)) begin
                        out_next.data_last = 1'b1;
                        phase_next         = PH_TRAIL;
                        step_next          = '0;
                    end
                end
                PH_TRAIL: begin
                    if (step_reg < STEP_W'(2)) begin
                        out_next.tx_valid    = 1'b1;
                        out_next.card_select = 1'b1;
                        out_next.tx_byte     = FILL_BYTE;
                        step_next            = step_inc;
                    end else begin
                        out_next.done_res   = 1'b1;
                        out_next.error_code = ERR_NONE;
                        phase_next          = PH_IDLE;
                        step_next           = '0;
                    end
                end
                default: begin
                    // idle: received bytes are dropped, result is all zero
                    phase_next = PH_IDLE;
                    step_next  = '0;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            offset_reg      <= OFFSET_RESET;
            resp_tries_reg  <= RESP_TRIES_RESET;
            token_tries_reg <= TOKEN_TRIES_RESET;
        end else if (cfg_we) begin
            case (cfg_index)
                REG_BLOCK_OFFSET:   offset_reg      <= cfg_data;
                REG_RESPONSE_TRIES: resp_tries_reg  <= cfg_data[7:0];
                REG_TOKEN_TRIES:    token_tries_reg <= cfg_data[9:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= PH_IDLE;
            step_reg      <= '0;
            addr_reg      <= '0;
            last_resp_reg <= FILL_BYTE;
            m_valid_reg   <= 1'b0;
        end else begin
            if (accept) begin
                phase_reg     <= phase_next;
                step_reg      <= step_next;
                addr_reg      <= addr_next;
                last_resp_reg <= last_resp_next;
                m_valid_reg   <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            out_reg <= out_next;
        end
    end

endmodule
`default_nettype wire

// ===== test/tb_sd_spi_block_read_sequencer_core.sv =====
`timescale 1ns / 100ps
module tb_sd_spi_block_read_sequencer_core;
    import sdrd_pkg::*;

    typedef enum logic [3:0] {
        RD_IDLE, RD_CMD, RD_RESP, RD_EXTRA, RD_TOKEN, RD_DATA, RD_TRAIL
    } rd_phase_e;

    typedef struct packed {
        sdrd_in_t  item;
        logic      typed;
        sdrd_out_t want;
    } dir_row_t;

    logic                  aclk;
    logic                  aresetn;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  s_valid;
    logic                  s_ready;
    sdrd_in_t              s_item;
    logic                  m_valid;
    logic                  m_ready;
    sdrd_out_t             m_item;

    sd_spi_block_read_sequencer_core i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_item    (s_item),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_item    (m_item)
    );

    // predicted sequencer state and its registers
    rd_phase_e   rd_phase;
    logic [9:0]  rd_step;
    logic [31:0] rd_addr;
    logic [7:0]  rd_last_resp;
    logic [23:0] cfg_offset;
    logic [7:0]  cfg_resp_tries;
    logic [9:0]  cfg_tok_tries;

    sdrd_out_t step_results_q[$];
    dir_row_t  dir_rows[$];
    int        n_bad;
    int        n_sent;
    int        stop_at;
    bit        tx_burst;
    bit        rx_burst;

    // shape of the card's answers for the read in flight
    int         resp_polls;
    logic [7:0] resp_val;
    int         tok_polls;
    logic [7:0] tok_val;

    function automatic sdrd_out_t tx_res(logic [7:0] b);
        sdrd_out_t r;
        r = '0;
        r.tx_valid = 1'b1;
        r.tx_byte = b;
        r.card_select = 1'b1;
        return r;
    endfunction

    function automatic sdrd_out_t end_of_read(logic [1:0] code, logic [7:0] fault);
        sdrd_out_t r;
        r = '0;
        r.done_res = 1'b1;
        r.error_code = code;
        r.fault_byte = fault;
        return r;
    endfunction

    function automatic sdrd_in_t start_req(logic [23:0] blk);
        sdrd_in_t it;
        it.req_type = REQ_START;
        it.block_number = blk;
        it.rx_byte = 8'($urandom);
        return it;
    endfunction

    function automatic sdrd_in_t rx_req(logic [7:0] b);
        sdrd_in_t it;
        it.req_type = REQ_RX;
        it.block_number = 24'($urandom);
        it.rx_byte = b;
        return it;
    endfunction

    function automatic sdrd_out_t read_step_result(sdrd_in_t it);
        sdrd_out_t   r;
        logic [23:0] blk;
        r = '0;
        if (it.req_type == REQ_START) begin
            blk = it.block_number + cfg_offset;
            rd_addr = {blk[22:0], 9'd0};
            rd_last_resp = FILL_BYTE;
            rd_phase = RD_CMD;
            rd_step = 10'd1;
            return tx_res(CMD_READ_SINGLE);
        end
        case (rd_phase)
            RD_CMD: begin
                if (rd_step >= 1 && rd_step <= 4) begin
                    r = tx_res(8'(rd_addr >> (32 - 8 * int'(rd_step))));
                    rd_step = rd_step + 1'b1;
                end else if (rd_step == 5) begin
                    r = tx_res(FILL_BYTE);
                    rd_step = 10'd6;
                end else begin
                    r = tx_res(FILL_BYTE);
                    rd_phase = RD_RESP;
                    rd_step = 10'd1;
                end
            end
            RD_RESP: begin
                r = tx_res(FILL_BYTE);
                if (it.rx_byte != FILL_BYTE || rd_step >= cfg_resp_tries) begin
                    rd_last_resp = it.rx_byte;
                    rd_phase = RD_EXTRA;
                    rd_step = '0;
                end else begin
                    rd_step = rd_step + 1'b1;
                end
            end
            RD_EXTRA: begin
                if (rd_last_resp != 8'h00) begin
                    r = end_of_read(ERR_RESPONSE, rd_last_resp);
                    rd_phase = RD_IDLE;
                    rd_step = '0;
                end else begin
                    r = tx_res(FILL_BYTE);
                    rd_phase = RD_TOKEN;
                    rd_step = 10'd1;
                end
            end
            RD_TOKEN: begin
                if (it.rx_byte == START_TOKEN) begin
                    r = tx_res(FILL_BYTE);
                    rd_phase = RD_DATA;
                    rd_step = '0;
                end else if (it.rx_byte != FILL_BYTE) begin
                    r = end_of_read(ERR_TOKEN, it.rx_byte);
                    rd_phase = RD_IDLE;
                    rd_step = '0;
                end else if (rd_step >= cfg_tok_tries) begin
                    r = end_of_read(ERR_TIMEOUT, it.rx_byte);
                    rd_phase = RD_IDLE;
                    rd_step = '0;
                end else begin
                    r = tx_res(FILL_BYTE);
                    rd_step = rd_step + 1'b1;
                end
            end
            RD_DATA: begin
                r = tx_res(FILL_BYTE);
                r.data_valid = 1'b1;
                r.data_byte = it.rx_byte;
                rd_step = rd_step + 1'b1;
                if (rd_step >= BLOCK_BYTES) begin
                    r.data_last = 1'b1;
                    rd_phase = RD_TRAIL;
                    rd_step = '0;
                end
            end
            RD_TRAIL: begin
                if (rd_step < 2) begin
                    r = tx_res(FILL_BYTE);
                    rd_step = rd_step + 1'b1;
                end else begin
                    r = end_of_read(ERR_NONE, 8'h00);
                    rd_phase = RD_IDLE;
                    rd_step = '0;
                end
            end
            default: begin
                // received byte with no read running: all-zero result
                rd_phase = RD_IDLE;
                rd_step = '0;
            end
        endcase
        return r;
    endfunction

    function automatic string fmt_res(sdrd_out_t r);
        return $sformatf("tx=%0b/%02h cs=%0b data=%0b/%02h last=%0b done=%0b err=%0d fault=%02h",
                         r.tx_valid, r.tx_byte, r.card_select, r.data_valid, r.data_byte,
                         r.data_last, r.done_res, r.error_code, r.fault_byte);
    endfunction

    function automatic void plan_read();
        resp_polls = ($urandom_range(0, 5) == 0) ? 300 : $urandom_range(0, 3);
        resp_val = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(1, 254)) : 8'h00;
        tok_polls = ($urandom_range(0, 15) == 0) ? 1100 : $urandom_range(0, 4);
        tok_val = ($urandom_range(0, 6) == 0) ? 8'($urandom_range(0, 253)) : START_TOKEN;
    endfunction

    // a read that runs through the whole block
    function automatic void plan_clean();
        resp_polls = $urandom_range(0, 3);
        resp_val = 8'h00;
        tok_polls = $urandom_range(0, 4);
        tok_val = START_TOKEN;
    endfunction

    // a read that ends at the R1 byte
    function automatic void plan_short();
        resp_polls = 0;
        resp_val = 8'h01;
    endfunction

    function automatic sdrd_in_t next_rx();
        sdrd_in_t it;
        it = rx_req(8'($urandom));
        if (rd_phase == RD_RESP) begin
            if (resp_polls > 0) begin
                it.rx_byte = FILL_BYTE;
                resp_polls--;
            end else begin
                it.rx_byte = resp_val;
            end
        end else if (rd_phase == RD_TOKEN) begin
            if (tok_polls > 0) begin
                it.rx_byte = FILL_BYTE;
                tok_polls--;
            end else begin
                it.rx_byte = tok_val;
            end
        end
        return it;
    endfunction

    // called at a falling edge; returns at the falling edge after acceptance
    task automatic send_item(input sdrd_in_t it, input logic typed, input sdrd_out_t want);
        int        gap;
        sdrd_out_t got;
        if ($urandom_range(0, 49) == 0) tx_burst = !tx_burst;
        gap = tx_burst ? 0 : $urandom_range(0, 11);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_item <= it;
        s_valid <= 1'b1;
        do @(posedge aclk); while (!s_ready);
        got = read_step_result(it);
        step_results_q.push_back(typed ? want : got);
        n_sent++;
        @(negedge aclk);
    endtask

    task automatic drain_results();
        s_valid <= 1'b0;
        do @(posedge aclk); while (step_results_q.size() != 0);
        @(negedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [23:0] data);
        @(negedge aclk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        case (idx)
            REG_BLOCK_OFFSET:   cfg_offset = data;
            REG_RESPONSE_TRIES: cfg_resp_tries = data[7:0];
            REG_TOKEN_TRIES:    cfg_tok_tries = data[9:0];
            default: ;
        endcase
        @(negedge aclk);
        cfg_we <= 1'b0;
    endtask

    // one read driven to its end; aborted now and then by a fresh start,
    // and cut short by a quickly failing read once the item budget is spent
    task automatic run_read(input bit resume, input bit clean);
        bit cut;
        cut = 1'b0;
        if (!resume) begin
            if (clean) plan_clean();
            else plan_read();
            send_item(start_req(24'($urandom)), 1'b0, '0);
        end
        while (rd_phase != RD_IDLE) begin
            if (!cut && n_sent >= stop_at) begin
                plan_short();
                cut = 1'b1;
                send_item(start_req(24'($urandom)), 1'b0, '0);
            end else if (!cut && $urandom_range(0, 399) == 0) begin
                plan_read();
                send_item(start_req(24'($urandom)), 1'b0, '0);
            end else begin
                send_item(next_rx(), 1'b0, '0);
            end
        end
    endtask

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    initial begin
        #4_000_000;
        $display("sd_spi_block_read_sequencer_core verification failed");
        $finish;
    end

    // result side: random stalls before each item
    initial begin
        int stall;
        m_ready = 1'b0;
        rx_burst = 1'b0;
        while (!aresetn) @(negedge aclk);
        forever begin
            if ($urandom_range(0, 49) == 0) rx_burst = !rx_burst;
            stall = rx_burst ? 0 : $urandom_range(0, 11);
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(negedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
            @(negedge aclk);
        end
    end

    always @(posedge aclk) begin
        sdrd_out_t want;
        if (aresetn && m_valid && m_ready) begin
            if (step_results_q.size() == 0) begin
                n_bad++;
                if (n_bad <= 10) $display("unexpected result: %s", fmt_res(m_item));
            end else begin
                want = step_results_q.pop_front();
                if (m_item !== want) begin
                    n_bad++;
                    if (n_bad <= 10) begin
                        $display("mismatch: expected %s", fmt_res(want));
                        $display("          actual   %s", fmt_res(m_item));
                    end
                end
            end
        end
    end

    initial begin
        logic [23:0] ph_offset[1:4];
        logic [7:0]  ph_resp[1:4];
        logic [9:0]  ph_tok[1:4];
        int          ph_first;
        bit          first_read;

        aresetn = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        s_valid = 1'b0;
        s_item = '0;
        n_bad = 0;
        n_sent = 0;
        stop_at = 0;
        tx_burst = 1'b0;
        rd_phase = RD_IDLE;
        rd_step = '0;
        rd_addr = '0;
        rd_last_resp = FILL_BYTE;
        cfg_offset = OFFSET_RESET;
        cfg_resp_tries = RESP_TRIES_RESET;
        cfg_tok_tries = TOKEN_TRIES_RESET;

        ph_offset[1] = 24'h000000;  ph_resp[1] = 8'd1;   ph_tok[1] = 10'd1;
        ph_offset[2] = 24'hFFFFFF;  ph_resp[2] = 8'd255; ph_tok[2] = 10'd1023;
        ph_offset[3] = 24'($urandom); ph_resp[3] = 8'd0;
        ph_tok[3] = 10'($urandom_range(2, 40));
        ph_offset[4] = 24'($urandom); ph_resp[4] = 8'($urandom_range(2, 16));
        ph_tok[4] = 10'($urandom_range(1, 64));

        // directed part, reset register values
        dir_rows.push_back('{rx_req(8'hFF), 1'b1, sdrd_out_t'('0)});   // byte while idle
        dir_rows.push_back('{start_req(24'h000000), 1'b1, tx_res(CMD_READ_SINGLE)});
        dir_rows.push_back('{rx_req(8'h00), 1'b0, sdrd_out_t'('0)});
        dir_rows.push_back('{rx_req(8'hFF), 1'b0, sdrd_out_t'('0)});
        dir_rows.push_back('{rx_req(8'h5A), 1'b0, sdrd_out_t'('0)});
        dir_rows.push_back('{rx_req(8'hA5), 1'b0, sdrd_out_t'('0)});
        dir_rows.push_back('{rx_req(8'h00), 1'b1, tx_res(FILL_BYTE)});
        dir_rows.push_back('{rx_req(8'h00), 1'b1, tx_res(FILL_BYTE)});
        dir_rows.push_back('{rx_req(8'h05), 1'b1, tx_res(FILL_BYTE)});  // bad R1
        dir_rows.push_back('{rx_req(8'hA7), 1'b1, end_of_read(ERR_RESPONSE, 8'h05)});
        dir_rows.push_back('{start_req(24'hFFFFFF), 1'b1, tx_res(CMD_READ_SINGLE)});
        dir_rows.push_back('{rx_req(8'h12), 1'b0, sdrd_out_t'('0)});
        dir_rows.push_back('{rx_req(8'h34), 1'b0, sdrd_out_t'('0)});
        dir_rows.push_back('{rx_req(8'h56), 1'b0, sdrd_out_t'('0)});
        dir_rows.push_back('{rx_req(8'h78), 1'b0, sdrd_out_t'('0)});
        dir_rows.push_back('{rx_req(8'hFF), 1'b1, tx_res(FILL_BYTE)});
        dir_rows.push_back('{rx_req(8'hFF), 1'b1, tx_res(FILL_BYTE)});
        dir_rows.push_back('{rx_req(8'hFF), 1'b1, tx_res(FILL_BYTE)});  // R1 poll
        dir_rows.push_back('{rx_req(8'h00), 1'b1, tx_res(FILL_BYTE)});
        dir_rows.push_back('{rx_req(8'h00), 1'b1, tx_res(FILL_BYTE)});  // extra clock
        dir_rows.push_back('{rx_req(8'hFF), 1'b1, tx_res(FILL_BYTE)});  // token poll
        dir_rows.push_back('{rx_req(8'h3C), 1'b1, end_of_read(ERR_TOKEN, 8'h3C)});
        dir_rows.push_back('{start_req(24'h123456), 1'b1, tx_res(CMD_READ_SINGLE)});
        dir_rows.push_back('{rx_req(8'h81), 1'b0, sdrd_out_t'('0)});
        // start while busy restarts the read
        dir_rows.push_back('{start_req(24'h000001), 1'b1, tx_res(CMD_READ_SINGLE)});

        repeat (10) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        foreach (dir_rows[i]) send_item(dir_rows[i].item, dir_rows[i].typed, dir_rows[i].want);
        stop_at = n_sent + 40;
        plan_read();
        run_read(1'b1, 1'b0);

        // the first set of registers gets room for full block reads
        for (int p = 0; p < 5; p++) begin
            if (p > 0) begin
                drain_results();
                write_reg(REG_BLOCK_OFFSET, ph_offset[p]);
                write_reg(REG_RESPONSE_TRIES, {16'd0, ph_resp[p]});
                write_reg(REG_TOKEN_TRIES, {14'd0, ph_tok[p]});
                @(negedge aclk);
            end
            ph_first = n_sent;
            stop_at = ph_first + ((p == 0) ? 700 : 130);
            first_read = (p == 0);
            while (n_sent < stop_at) begin
                if ($urandom_range(0, 19) == 0) drain_results();
                if ($urandom_range(0, 7) == 0) begin
                    repeat ($urandom_range(1, 3)) send_item(rx_req(8'($urandom)), 1'b0, '0);
                end
                run_read(1'b0, first_read);
                first_read = 1'b0;
            end
        end

        s_valid <= 1'b0;
        while (step_results_q.size() != 0) @(posedge aclk);
        repeat (16) @(posedge aclk);
        if (n_bad == 0) begin
            $display("sd_spi_block_read_sequencer_core verification clean");
        end else begin
            $display("sd_spi_block_read_sequencer_core verification failed");
        end
        $finish;
    end

endmodule
